// ===== src/dtlp_pkg.sv =====
`timescale 1ns / 1ps

package dtlp_pkg;

  // button channels handled by the block
  localparam int unsigned Channels = 4;

  // fixed widths of the payload and configuration fields
  localparam int unsigned FieldW   = 4;
  localparam int unsigned DbCntW   = 8;
  localparam int unsigned HoldCntW = 16;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDebounceThr = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgLongPressThr = 8'd1;

  // register reset values
  localparam logic [DbCntW-1:0]   DebounceThrRst  = 8'd10;
  localparam logic [HoldCntW-1:0] LongPressThrRst = 16'd600;

  // one tick result as it sits in the output register
  typedef struct packed {
    logic [FieldW-1:0] output_levels;
    logic [FieldW-1:0] debounced_levels;
    logic [FieldW-1:0] input_changed;
    logic [FieldW-1:0] output_toggled;
    logic [FieldW-1:0] long_press;
  } result_t;

endpackage

// ===== src/debounce_toggle_long_press.sv =====
`timescale 1ns / 1ps

// push-button debouncer with toggle outputs and long-press detection
//
// input channel: in_valid_i / in_ready_o carry one scan tick, the two raw
// samples of every button channel (first_samples_i, second_samples_i)
// output channel: out_valid_o / out_ready_i carry one result per tick with
// output latches, debounced levels and the changed, toggled and long-press
// flags of that tick
// config channel: cfg_valid_i / cfg_ready_o write debounce_threshold
// (index 0) or long_press_threshold (index 1); other indexes are dropped;
// cfg_ready_o is always high; write only while no request is in flight
//
// a tick is worked out in the cycle it is accepted and its result
// shows on the output register in the next cycle
// throughput: one tick per cycle, set by the single result register; a new
// tick is taken whenever that register is empty or is being drained
// when the receiver stalls, the result holds and in_ready_o falls until the
// result is taken, so no tick is lost
// reset: levels read released (all ones), output latches and counters are
// cleared, thresholds return to 10 and 600, the output register is empty
module debounce_toggle_long_press (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [dtlp_pkg::FieldW-1:0]      first_samples_i,
  input  logic [dtlp_pkg::FieldW-1:0]      second_samples_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [dtlp_pkg::FieldW-1:0]      output_levels_o,
  output logic [dtlp_pkg::FieldW-1:0]      debounced_levels_o,
  output logic [dtlp_pkg::FieldW-1:0]      input_changed_o,
  output logic [dtlp_pkg::FieldW-1:0]      output_toggled_o,
  output logic [dtlp_pkg::FieldW-1:0]      long_press_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dtlp_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [dtlp_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int unsigned Ch = dtlp_pkg::Channels;
  localparam int unsigned DbW = dtlp_pkg::DbCntW;
  localparam int unsigned HoW = dtlp_pkg::HoldCntW;

  logic [DbW-1:0] db_thr_q;
  logic [HoW-1:0] lp_thr_q;
  logic [DbW-1:0] db_thr;
  logic [HoW-1:0] lp_thr;

  logic [Ch-1:0]  level_q, level_d;
  logic [Ch-1:0]  latch_q, latch_d;
  logic [DbW-1:0] db_cnt_q [Ch];
  logic [DbW-1:0] db_cnt_d [Ch];
  logic [HoW-1:0] hold_q [Ch];
  logic [HoW-1:0] hold_d [Ch];

  logic                 out_valid_q;
  dtlp_pkg::result_t    res_q, res_d;
  logic                 in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ~out_valid_q | out_ready_i;
  assign in_fire     = in_valid_i & in_ready_o;

  // a threshold written as zero acts as one
  assign db_thr = (db_thr_q == '0) ? DbW'(1) : db_thr_q;
  assign lp_thr = (lp_thr_q == '0) ? HoW'(1) : lp_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      db_thr_q <= dtlp_pkg::DebounceThrRst;
      lp_thr_q <= dtlp_pkg::LongPressThrRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == dtlp_pkg::CfgDebounceThr) begin
        db_thr_q <= cfg_data_i[DbW-1:0];
      end else if (cfg_index_i == dtlp_pkg::CfgLongPressThr) begin
        lp_thr_q <= cfg_data_i[HoW-1:0];
      end
    end
  end

  always_comb begin
    level_d = level_q;
    latch_d = latch_q;
    res_d   = '0;
    for (int c = 0; c < Ch; c++) begin
      db_cnt_d[c] = db_cnt_q[c];
      hold_d[c]   = hold_q[c];
      if (level_q[c] != first_samples_i[c]) begin
        hold_d[c] = '0;
        if (level_q[c] != second_samples_i[c]) begin
          if (db_cnt_q[c] != '1) begin
            db_cnt_d[c] = db_cnt_q[c] + DbW'(1);
          end
        end else begin
          db_cnt_d[c] = '0;
        end
        if (db_cnt_d[c] >= db_thr) begin
          // confirmed press: released to pressed
          if (level_q[c] && !second_samples_i[c]) begin
            latch_d[c] = ~latch_q[c];
            hold_d[c]  = HoW'(1);
            res_d.output_toggled[c] = 1'b1;
          end
          level_d[c]  = second_samples_i[c];
          db_cnt_d[c] = '0;
          res_d.input_changed[c] = 1'b1;
        end
      end else if (hold_q[c] != '0) begin
        if (level_q[c] == second_samples_i[c]) begin
          if (hold_q[c] != '1) begin
            hold_d[c] = hold_q[c] + HoW'(1);
          end
        end else begin
          hold_d[c] = '0;
        end
        if (hold_d[c] >= lp_thr) begin
          hold_d[c] = '0;
          res_d.long_press[c] = 1'b1;
        end
      end
      res_d.output_levels[c]    = latch_d[c];
      res_d.debounced_levels[c] = level_d[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '1;
      latch_q <= '0;
      for (int c = 0; c < Ch; c++) begin
        db_cnt_q[c] <= '0;
        hold_q[c]   <= '0;
      end
    end else if (in_fire) begin
      level_q <= level_d;
      latch_q <= latch_d;
      for (int c = 0; c < Ch; c++) begin
        db_cnt_q[c] <= db_cnt_d[c];
        hold_q[c]   <= hold_d[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign output_levels_o    = res_q.output_levels;
  assign debounced_levels_o = res_q.debounced_levels;
  assign input_changed_o    = res_q.input_changed;
  assign output_toggled_o   = res_q.output_toggled;
  assign long_press_o       = res_q.long_press;

`ifndef ASSERT_OFF
  // a toggle only comes with an accepted change to the pressed level
  a_toggle_is_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((output_toggled_o & ~(input_changed_o & ~debounced_levels_o)) == '0))
    else $error("toggle without a confirmed press");

  // a channel cannot change level and finish a long press in the same tick
  a_long_press_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((long_press_o & input_changed_o) == '0))
    else $error("long press on a tick with a level change");

  // a stalled result is kept until taken
  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(res_q)))
    else $error("stalled result lost or changed");
`endif

endmodule

// ===== bench/debounce_toggle_long_press_test.sv =====
`timescale 1ns / 1ps

module debounce_toggle_long_press_test;
  import dtlp_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned StallLen   = 80;

  typedef struct {
    logic [FieldW-1:0] first;
    logic [FieldW-1:0] second;
  } scan_tick_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [FieldW-1:0]   first_samples_i = '1;
  logic [FieldW-1:0]   second_samples_i = '1;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [FieldW-1:0]   output_levels_o;
  logic [FieldW-1:0]   debounced_levels_o;
  logic [FieldW-1:0]   input_changed_o;
  logic [FieldW-1:0]   output_toggled_o;
  logic [FieldW-1:0]   long_press_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // predicted block state
  logic [DbCntW-1:0]   debounce_thr;
  logic [HoldCntW-1:0] long_press_thr;
  logic                level_q [Channels];
  logic                latch_q [Channels];
  logic [DbCntW-1:0]   bounce_cnt [Channels];
  logic [HoldCntW-1:0] held_cnt [Channels];

  scan_tick_t scan_ticks_queued [$];
  result_t    tick_results_due [$];

  int unsigned ticks_queued_total = 0;
  int unsigned ticks_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_requests = 0;
  int unsigned stalls_served = 0;
  int unsigned stall_left = 0;
  logic        in_fire = 1'b0;

  debounce_toggle_long_press dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .first_samples_i    (first_samples_i),
    .second_samples_i   (second_samples_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .output_levels_o    (output_levels_o),
    .debounced_levels_o (debounced_levels_o),
    .input_changed_o    (input_changed_o),
    .output_toggled_o   (output_toggled_o),
    .long_press_o       (long_press_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic reset_button_state();
    debounce_thr   = DebounceThrRst;
    long_press_thr = LongPressThrRst;
    for (int c = 0; c < Channels; c++) begin
      level_q[c]    = 1'b1;
      latch_q[c]    = 1'b0;
      bounce_cnt[c] = '0;
      held_cnt[c]   = '0;
    end
  endtask

  // one scan tick of every channel, result goes to the back of the due list
  task automatic predict_scan_tick(input logic [FieldW-1:0] s1, input logic [FieldW-1:0] s2);
    result_t             r;
    logic [DbCntW-1:0]   db_lim;
    logic [HoldCntW-1:0] lp_lim;
    logic                a;
    logic                b;
    r      = '0;
    db_lim = (debounce_thr == '0) ? DbCntW'(1) : debounce_thr;
    lp_lim = (long_press_thr == '0) ? HoldCntW'(1) : long_press_thr;
    for (int c = 0; c < Channels; c++) begin
      a = s1[c];
      b = s2[c];
      if (a != level_q[c]) begin
        held_cnt[c] = '0;
        if (b != level_q[c]) begin
          if (bounce_cnt[c] != '1) bounce_cnt[c]++;
        end else begin
          bounce_cnt[c] = '0;
        end
        if (bounce_cnt[c] >= db_lim) begin
          // confirmed press toggles the latch and starts hold timing
          if (level_q[c] && !b) begin
            latch_q[c]          = ~latch_q[c];
            held_cnt[c]         = HoldCntW'(1);
            r.output_toggled[c] = 1'b1;
          end
          level_q[c]         = b;
          bounce_cnt[c]      = '0;
          r.input_changed[c] = 1'b1;
        end
      end else if (held_cnt[c] != '0) begin
        if (b == level_q[c]) begin
          if (held_cnt[c] != '1) held_cnt[c]++;
        end else begin
          held_cnt[c] = '0;
        end
        if (held_cnt[c] >= lp_lim) begin
          r.long_press[c] = 1'b1;
          held_cnt[c]     = '0;
        end
      end
      r.output_levels[c]    = latch_q[c];
      r.debounced_levels[c] = level_q[c];
    end
    tick_results_due.push_back(r);
  endtask

  task automatic compare_tick(input result_t got, input result_t exp);
    string names [5];
    names = '{"long_press", "output_toggled", "input_changed", "debounced_levels",
              "output_levels"};
    for (int f = 0; f < 5; f++) begin
      if (got[f*FieldW +: FieldW] !== exp[f*FieldW +: FieldW])
        report_mismatch($sformatf("%s got %b expected %b", names[f],
                                  got[f*FieldW +: FieldW], exp[f*FieldW +: FieldW]));
    end
  endtask

  // monitor: sampled at the rising edge, inputs are stable since the falling edge
  always @(posedge clk_i) begin
    result_t seen;
    if (rst_ni) begin
      in_fire = in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        seen = '{output_levels: output_levels_o, debounced_levels: debounced_levels_o,
                 input_changed: input_changed_o, output_toggled: output_toggled_o,
                 long_press: long_press_o};
        if (tick_results_due.size() == 0)
          report_mismatch($sformatf("result %h with no tick pending", seen));
        else
          compare_tick(seen, tick_results_due.pop_front());
      end
      if (in_fire) begin
        predict_scan_tick(first_samples_i, second_samples_i);
        ticks_sent++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgDebounceThr:  debounce_thr = cfg_data_i[DbCntW-1:0];
          CfgLongPressThr: long_press_thr = cfg_data_i;
          default: ;
        endcase
        cfg_writes++;
      end
    end
  end

  // request driver
  always @(negedge clk_i) begin
    scan_tick_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (scan_ticks_queued.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = scan_ticks_queued.pop_front();
        in_valid_i       <= 1'b1;
        first_samples_i  <= nxt.first;
        second_samples_i <= nxt.second;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (stalls_served != stall_requests) begin
      stalls_served = stall_requests;
      stall_left    = StallLen;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_tick(input logic [FieldW-1:0] s1, input logic [FieldW-1:0] s2);
    scan_tick_t t;
    t.first  = s1;
    t.second = s2;
    scan_ticks_queued.push_back(t);
    ticks_queued_total++;
  endtask

  // buttons held for random runs, with contact bounce and some line noise
  task automatic queue_button_activity(input int n, input int max_run, input int bounce_pct);
    logic [FieldW-1:0] target;
    logic [FieldW-1:0] s1;
    logic [FieldW-1:0] s2;
    int                run_left [Channels];
    target = FieldW'($urandom);
    for (int c = 0; c < Channels; c++) run_left[c] = $urandom_range(max_run);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 6) begin
        s1 = FieldW'($urandom);
        s2 = FieldW'($urandom);
      end else begin
        for (int c = 0; c < Channels; c++) begin
          if (run_left[c] == 0) begin
            target[c]   = ~target[c];
            run_left[c] = $urandom_range(max_run, 1);
          end else begin
            run_left[c]--;
          end
        end
        s1 = target;
        s2 = target;
        for (int c = 0; c < Channels; c++) begin
          if ($urandom_range(99) < bounce_pct) s1[c] = ~s1[c];
          if ($urandom_range(99) < bounce_pct) s2[c] = ~s2[c];
        end
      end
      queue_tick(s1, s2);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (ticks_sent != ticks_queued_total || tick_results_due.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    int unsigned n;
    @(negedge clk_i);
    n = cfg_writes;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i);
    while (cfg_writes == n);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    reset_button_state();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset thresholds: clean press, bounce patterns, then release
    send_idle_pct = 35;
    recv_idle_pct = 74;
    queue_tick(4'hF, 4'hF);
    repeat (11) queue_tick(4'h0, 4'h0);
    queue_tick(4'h0, 4'hF);
    queue_tick(4'hF, 4'h0);
    queue_tick(4'hA, 4'h5);
    queue_tick(4'h5, 4'hA);
    repeat (11) queue_tick(4'hF, 4'hF);
    queue_button_activity(200, 40, 3);
    wait_drained();

    write_reg(CfgDebounceThr, 16'd1);
    write_reg(CfgLongPressThr, 16'd1);
    queue_button_activity(250, 8, 10);
    stall_requests++;
    wait_drained();

    // zero thresholds act as one; unused data bits and unknown indexes dropped
    send_idle_pct = 74;
    recv_idle_pct = 35;
    write_reg(CfgDebounceThr, {8'($urandom_range(255, 1)), 8'd0});
    write_reg(CfgLongPressThr, 16'd0);
    write_reg(8'd2, 16'hFFFF);
    write_reg(8'hFF, 16'h0003);
    queue_button_activity(200, 8, 10);
    wait_drained();

    write_reg(CfgDebounceThr, 16'd3);
    write_reg(CfgLongPressThr, 16'd20);
    queue_button_activity(350, 40, 5);
    stall_requests++;
    wait_drained();

    // widest thresholds: a press needs a full 255 steady ticks
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CfgDebounceThr, 16'hFFFF);
    write_reg(CfgLongPressThr, 16'hFFFF);
    repeat (258) queue_tick(4'h0, 4'h0);
    repeat (12) queue_tick(4'hF, 4'hF);
    wait_drained();

    write_reg(CfgDebounceThr, 16'd2);
    write_reg(CfgLongPressThr, 16'd7);
    queue_button_activity(450, 20, 8);
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
